>>> rtl/pjd_pkg.sv
// shared constants, field widths, microcode word and flag types for the job dispatcher
// no dependencies; used by pjd_seq and per_core_priority_job_dispatcher
package pjd_pkg;

  localparam int MAX_CORES      = 8;
  localparam int NUM_PRIORITIES = 3;
  localparam int QUEUE_DEPTH    = 16;
  localparam int TAG_WIDTH      = 32;

  localparam int NUM_QUEUES  = MAX_CORES * NUM_PRIORITIES;
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  // item field widths
  localparam int PRIO_W   = 2;
  localparam int HINT_W   = 16;
  localparam int CORE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam int REM_W  = CORE_W + 1;
  localparam int Q_W    = $clog2(NUM_QUEUES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(HINT_W);
  localparam int PC_W   = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_TARGET,
    OP_ENQ,
    OP_SCAN,
    OP_NEXT,
    OP_TAKE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_FETCH,
    COND_DIV_BUSY,
    COND_HIT,
    COND_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] jump;
    logic [PC_W-1:0] next;
  } uword_t;

  typedef struct packed {
    logic no_in;
    logic is_fetch;
    logic div_busy;
    logic hit;
    logic more;
    logic out_busy;
  } flags_t;

endpackage

>>> rtl/pjd_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module pjd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pjd_seq.sv
// microcode sequencer: step counter, control store and conditional next-step select
// depends on pjd_pkg
module pjd_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pjd_pkg::flags_t flags_i,
  output pjd_pkg::uword_t uword_o
);

  localparam logic [pjd_pkg::PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_DISPATCH = 4'd1;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_DIV_LOAD = 4'd2;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_DIV_STEP = 4'd3;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_TARGET   = 4'd4;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_ENQ      = 4'd5;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_SCAN     = 4'd6;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_NEXT     = 4'd7;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_TAKE     = 4'd8;
  localparam logic [pjd_pkg::PC_W-1:0] STEP_EMIT     = 4'd9;

  function automatic pjd_pkg::uword_t rom(input logic [pjd_pkg::PC_W-1:0] pc);
    pjd_pkg::uword_t uw;
    case (pc)
      STEP_IDLE: begin
        uw = '{op: pjd_pkg::OP_LATCH, cond: pjd_pkg::COND_NO_IN,
               jump: STEP_IDLE, next: STEP_DISPATCH};
      end
      STEP_DISPATCH: begin
        uw = '{op: pjd_pkg::OP_NOP, cond: pjd_pkg::COND_FETCH,
               jump: STEP_SCAN, next: STEP_DIV_LOAD};
      end
      STEP_DIV_LOAD: begin
        uw = '{op: pjd_pkg::OP_DIV_LOAD, cond: pjd_pkg::COND_NONE,
               jump: STEP_IDLE, next: STEP_DIV_STEP};
      end
      STEP_DIV_STEP: begin
        uw = '{op: pjd_pkg::OP_DIV_STEP, cond: pjd_pkg::COND_DIV_BUSY,
               jump: STEP_DIV_STEP, next: STEP_TARGET};
      end
      STEP_TARGET: begin
        uw = '{op: pjd_pkg::OP_TARGET, cond: pjd_pkg::COND_NONE,
               jump: STEP_IDLE, next: STEP_ENQ};
      end
      STEP_ENQ: begin
        uw = '{op: pjd_pkg::OP_ENQ, cond: pjd_pkg::COND_NONE,
               jump: STEP_IDLE, next: STEP_EMIT};
      end
      STEP_SCAN: begin
        uw = '{op: pjd_pkg::OP_SCAN, cond: pjd_pkg::COND_HIT,
               jump: STEP_TAKE, next: STEP_NEXT};
      end
      STEP_NEXT: begin
        uw = '{op: pjd_pkg::OP_NEXT, cond: pjd_pkg::COND_MORE,
               jump: STEP_SCAN, next: STEP_EMIT};
      end
      STEP_TAKE: begin
        uw = '{op: pjd_pkg::OP_TAKE, cond: pjd_pkg::COND_NONE,
               jump: STEP_IDLE, next: STEP_EMIT};
      end
      STEP_EMIT: begin
        uw = '{op: pjd_pkg::OP_EMIT, cond: pjd_pkg::COND_OUT_BUSY,
               jump: STEP_EMIT, next: STEP_IDLE};
      end
      default: begin
        uw = '{op: pjd_pkg::OP_NOP, cond: pjd_pkg::COND_NONE,
               jump: STEP_IDLE, next: STEP_IDLE};
      end
    endcase
    return uw;
  endfunction

  logic [pjd_pkg::PC_W-1:0] pc_q, pc_d;
  pjd_pkg::uword_t          uword;
  logic                     take_jump;

  assign uword = rom(pc_q);

  always_comb begin
    case (uword.cond)
      pjd_pkg::COND_NO_IN:    take_jump = flags_i.no_in;
      pjd_pkg::COND_FETCH:    take_jump = flags_i.is_fetch;
      pjd_pkg::COND_DIV_BUSY: take_jump = flags_i.div_busy;
      pjd_pkg::COND_HIT:      take_jump = flags_i.hit;
      pjd_pkg::COND_MORE:     take_jump = flags_i.more;
      pjd_pkg::COND_OUT_BUSY: take_jump = flags_i.out_busy;
      default:                take_jump = 1'b0;
    endcase
    pc_d = take_jump ? uword.jump : uword.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uword_o = uword;

endmodule

>>> rtl/per_core_priority_job_dispatcher.sv
// top level of the per-core priority job dispatcher: datapath, queue pointers, output register
// depends on pjd_pkg, pjd_seq and pjd_ram
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata job, prio, hint, core; tuser func
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata core, job, prio; tuser status
//   cfg       in         cfg_valid_i / cfg_ready_o      active core count, 4 bits
//
// a submit runs the 16-step bit-serial modulo of its hint or the round-robin counter before
// its result is offered; a fetch spends one scan step pair per empty priority class and,
// on a hit, a take step for the registered tag read. a new item is taken the cycle after
// the result moves into the output register, which holds it until the sink takes it.
// reset empties all queues, clears the round-robin counter and sets the core count to 8.
module per_core_priority_job_dispatcher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // job_tag[31:0], priority_req[33:32], hint_valid[34], hint_core[50:35], fetch_core[53:51]
  input  logic [pjd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // core_out[2:0], job_out[34:3], priority_out[36:35]
  output logic [pjd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [pjd_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pjd_pkg::CFG_W-1:0]      cfg_data_i
);

  pjd_pkg::uword_t uword;
  pjd_pkg::flags_t flags;

  // control state
  logic [pjd_pkg::CFG_W-1:0]  cores_q;
  logic [pjd_pkg::CORE_W-1:0] rr_q;
  logic [pjd_pkg::FILL_W-1:0] fill_q [pjd_pkg::NUM_QUEUES];
  logic [pjd_pkg::PTR_W-1:0]  head_q [pjd_pkg::NUM_QUEUES];
  logic [pjd_pkg::PTR_W-1:0]  tail_q [pjd_pkg::NUM_QUEUES];
  logic                       m_valid_q;

  // item registers and datapath
  logic                         func_q;
  logic [pjd_pkg::TAG_WIDTH-1:0] tag_q;
  logic [pjd_pkg::PRIO_W-1:0]   prio_q;
  logic                         hv_q;
  logic [pjd_pkg::HINT_W-1:0]   hint_q;
  logic [pjd_pkg::CORE_W-1:0]   fcore_q;
  logic [pjd_pkg::HINT_W-1:0]   div_q;
  logic [pjd_pkg::REM_W-1:0]    rem_q;
  logic [pjd_pkg::CNT_W-1:0]    cnt_q;
  logic [pjd_pkg::CORE_W-1:0]   core_q;
  logic [pjd_pkg::Q_W-1:0]      q_q;
  logic [pjd_pkg::PRIO_W-1:0]   p_q;

  // result staging and output register
  pjd_pkg::status_e              res_status_q, out_status_q;
  logic [pjd_pkg::CORE_W-1:0]    res_core_q, out_core_q;
  logic [pjd_pkg::TAG_WIDTH-1:0] res_job_q, out_job_q;
  logic [pjd_pkg::PRIO_W-1:0]    res_prio_q, out_prio_q;

  logic                          in_fire;
  logic [pjd_pkg::PRIO_W-1:0]    in_prio;
  logic [pjd_pkg::PRIO_W-1:0]    in_prio_sat;
  logic [pjd_pkg::CORE_W-1:0]    in_fcore;
  logic [pjd_pkg::REM_W-1:0]     n_eff;
  logic [pjd_pkg::REM_W-1:0]     trial;
  logic                          trial_ge;
  logic [pjd_pkg::REM_W-1:0]     rem_inc;
  logic [pjd_pkg::FILL_W-1:0]    cur_fill;
  logic [pjd_pkg::PTR_W-1:0]     cur_head;
  logic [pjd_pkg::PTR_W-1:0]     cur_tail;
  logic [pjd_pkg::PTR_W-1:0]     head_inc;
  logic [pjd_pkg::PTR_W-1:0]     tail_inc;
  logic                          core_ok;
  logic                          q_full;
  logic                          out_busy;
  logic                          ram_we;
  logic                          ram_re;
  logic [pjd_pkg::ADDR_W-1:0]    ram_waddr;
  logic [pjd_pkg::ADDR_W-1:0]    ram_raddr;
  logic [pjd_pkg::TAG_WIDTH-1:0] ram_rdata;

  pjd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  pjd_ram #(
    .WIDTH (pjd_pkg::TAG_WIDTH),
    .DEPTH (pjd_pkg::STORE_DEPTH)
  ) u_tag_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (uword.op == pjd_pkg::OP_LATCH);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_prio  = s_axis_tdata[33:32];
  assign in_fcore = s_axis_tdata[53:51];
  assign in_prio_sat = (in_prio >= pjd_pkg::PRIO_W'(pjd_pkg::NUM_PRIORITIES)) ?
                       pjd_pkg::PRIO_W'(pjd_pkg::NUM_PRIORITIES - 1) : in_prio;

  // zero reads as one core, anything above MAX_CORES saturates to MAX_CORES
  always_comb begin
    if (cores_q == '0) begin
      n_eff = pjd_pkg::REM_W'(1);
    end else if (pjd_pkg::REM_W'(cores_q) > pjd_pkg::REM_W'(pjd_pkg::MAX_CORES)) begin
      n_eff = pjd_pkg::REM_W'(pjd_pkg::MAX_CORES);
    end else begin
      n_eff = pjd_pkg::REM_W'(cores_q);
    end
  end

  // restoring modulo, one dividend bit per step
  assign trial    = {rem_q[pjd_pkg::REM_W-2:0], div_q[pjd_pkg::HINT_W-1]};
  assign trial_ge = (trial >= n_eff);
  assign rem_inc  = rem_q + pjd_pkg::REM_W'(1);

  assign cur_fill = fill_q[q_q];
  assign cur_head = head_q[q_q];
  assign cur_tail = tail_q[q_q];
  assign head_inc = (cur_head == pjd_pkg::PTR_W'(pjd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : cur_head + pjd_pkg::PTR_W'(1);
  assign tail_inc = (cur_tail == pjd_pkg::PTR_W'(pjd_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : cur_tail + pjd_pkg::PTR_W'(1);

  assign core_ok  = (pjd_pkg::REM_W'(fcore_q) < pjd_pkg::REM_W'(pjd_pkg::MAX_CORES));
  assign q_full   = (cur_fill == pjd_pkg::FILL_W'(pjd_pkg::QUEUE_DEPTH));
  assign out_busy = m_valid_q && !m_axis_tready;

  assign flags.no_in    = !s_axis_tvalid;
  assign flags.is_fetch = func_q;
  assign flags.div_busy = (cnt_q != pjd_pkg::CNT_W'(pjd_pkg::HINT_W - 1));
  assign flags.hit      = core_ok && (cur_fill != '0);
  assign flags.more     = core_ok && (p_q != pjd_pkg::PRIO_W'(pjd_pkg::NUM_PRIORITIES - 1));
  assign flags.out_busy = out_busy;

  assign ram_we    = (uword.op == pjd_pkg::OP_ENQ) && !q_full;
  assign ram_re    = (uword.op == pjd_pkg::OP_SCAN) && flags.hit;
  assign ram_waddr = pjd_pkg::ADDR_W'(q_q) * pjd_pkg::ADDR_W'(pjd_pkg::QUEUE_DEPTH)
                     + pjd_pkg::ADDR_W'(cur_tail);
  assign ram_raddr = pjd_pkg::ADDR_W'(q_q) * pjd_pkg::ADDR_W'(pjd_pkg::QUEUE_DEPTH)
                     + pjd_pkg::ADDR_W'(cur_head);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_q   <= pjd_pkg::CFG_W'(pjd_pkg::MAX_CORES);
      rr_q      <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < pjd_pkg::NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cores_q <= cfg_data_i;
      end
      // the counter advances even when the chosen queue turns out full
      if (uword.op == pjd_pkg::OP_TARGET && !hv_q) begin
        rr_q <= (rem_inc == n_eff) ? '0 : rem_inc[pjd_pkg::CORE_W-1:0];
      end
      if (uword.op == pjd_pkg::OP_ENQ && !q_full) begin
        tail_q[q_q] <= tail_inc;
        fill_q[q_q] <= cur_fill + pjd_pkg::FILL_W'(1);
      end
      if (uword.op == pjd_pkg::OP_SCAN && flags.hit) begin
        head_q[q_q] <= head_inc;
        fill_q[q_q] <= cur_fill - pjd_pkg::FILL_W'(1);
      end
      if (uword.op == pjd_pkg::OP_EMIT && !out_busy) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uword.op)
      pjd_pkg::OP_LATCH: begin
        if (in_fire) begin
          func_q  <= s_axis_tuser[0];
          tag_q   <= s_axis_tdata[31:0];
          prio_q  <= in_prio_sat;
          hv_q    <= s_axis_tdata[34];
          hint_q  <= s_axis_tdata[50:35];
          fcore_q <= in_fcore;
          p_q     <= '0;
          q_q     <= pjd_pkg::Q_W'(in_fcore) * pjd_pkg::Q_W'(pjd_pkg::NUM_PRIORITIES);
        end
      end
      pjd_pkg::OP_DIV_LOAD: begin
        div_q <= hv_q ? hint_q : pjd_pkg::HINT_W'(rr_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      pjd_pkg::OP_DIV_STEP: begin
        rem_q <= trial_ge ? trial - n_eff : trial;
        div_q <= {div_q[pjd_pkg::HINT_W-2:0], 1'b0};
        cnt_q <= cnt_q + pjd_pkg::CNT_W'(1);
      end
      pjd_pkg::OP_TARGET: begin
        core_q <= rem_q[pjd_pkg::CORE_W-1:0];
        q_q    <= pjd_pkg::Q_W'(rem_q[pjd_pkg::CORE_W-1:0])
                  * pjd_pkg::Q_W'(pjd_pkg::NUM_PRIORITIES) + pjd_pkg::Q_W'(prio_q);
      end
      pjd_pkg::OP_ENQ: begin
        res_status_q <= q_full ? pjd_pkg::ST_FULL : pjd_pkg::ST_QUEUED;
        res_core_q   <= core_q;
        res_job_q    <= '0;
        res_prio_q   <= prio_q;
      end
      pjd_pkg::OP_SCAN: begin
        if (flags.hit) begin
          res_status_q <= pjd_pkg::ST_DELIVERED;
          res_core_q   <= fcore_q;
          res_prio_q   <= p_q;
        end
      end
      pjd_pkg::OP_NEXT: begin
        if (flags.more) begin
          p_q <= p_q + pjd_pkg::PRIO_W'(1);
          q_q <= q_q + pjd_pkg::Q_W'(1);
        end else begin
          res_status_q <= pjd_pkg::ST_EMPTY;
          res_core_q   <= fcore_q;
          res_job_q    <= '0;
          res_prio_q   <= '0;
        end
      end
      pjd_pkg::OP_TAKE: begin
        res_job_q <= ram_rdata;
      end
      pjd_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_status_q <= res_status_q;
          out_core_q   <= res_core_q;
          out_job_q    <= res_job_q;
          out_prio_q   <= res_prio_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, out_prio_q, out_job_q, out_core_q};
  assign m_axis_tuser  = out_status_q;

endmodule

>>> dv/tb_per_core_priority_job_dispatcher.sv
// self-checking testbench for the per-core priority job dispatcher: directed rows, then random
// phases over several core-count settings, scored against an in-bench queue predictor
// depends on pjd_pkg and per_core_priority_job_dispatcher
module tb_per_core_priority_job_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    FN_SUBMIT = 1'b0,
    FN_FETCH  = 1'b1
  } func_e;

  typedef struct packed {
    func_e         func;
    logic [31:0]   job_tag;
    logic [1:0]    prio;
    logic          hint_valid;
    logic [15:0]   hint_core;
    logic [2:0]    fetch_core;
  } job_item_t;

  typedef struct packed {
    pjd_pkg::status_e status;
    logic [2:0]       core;
    logic [31:0]      job;
    logic [1:0]       prio;
  } dispatch_res_t;

  typedef struct {
    bit            is_cfg;
    logic [3:0]    cfg_val;
    job_item_t     it;
    bit            typed;
    dispatch_res_t res;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_GUARD   = 30;
  localparam int EXP_DEPTH    = 16;
  localparam int ROW_DEPTH    = 32;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pjd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pjd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [pjd_pkg::STATUS_W-1:0]   m_axis_tuser;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [pjd_pkg::CFG_W-1:0]      cfg_data_i = '0;

  per_core_priority_job_dispatcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0]  tag_mem [pjd_pkg::NUM_QUEUES*pjd_pkg::QUEUE_DEPTH];
  int unsigned  q_fill [pjd_pkg::NUM_QUEUES];
  int unsigned  q_head [pjd_pkg::NUM_QUEUES];
  int unsigned  q_tail [pjd_pkg::NUM_QUEUES];
  int unsigned  rr_next;
  logic [3:0]   cfg_cores;

  // expected results in flight, written by the sender and read by the sink
  dispatch_res_t exp_buf [EXP_DEPTH];
  int            exp_wr = 0;
  int            exp_rd = 0;
  stim_row_t     stim_rows [ROW_DEPTH];
  int            n_rows = 0;

  int  fail_count = 0;
  int  report_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  settings_used = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  int  sink_stall = 0;
  bit  sink_calm = 1'b0;
  bit  send_calm = 1'b0;

  function automatic dispatch_res_t dispatch_predict(job_item_t it);
    dispatch_res_t r;
    int unsigned   n;
    int unsigned   tgt;
    int unsigned   p;
    int unsigned   q;
    bit            found;
    r = '{status: pjd_pkg::ST_EMPTY, core: it.fetch_core, job: '0, prio: '0};
    if (it.func == FN_SUBMIT) begin
      n = (cfg_cores == 0) ? 1 :
          ((cfg_cores > pjd_pkg::MAX_CORES) ? pjd_pkg::MAX_CORES : cfg_cores);
      p = (it.prio >= pjd_pkg::NUM_PRIORITIES) ? pjd_pkg::NUM_PRIORITIES - 1 : it.prio;
      if (it.hint_valid) begin
        tgt = it.hint_core % n;
      end else begin
        tgt = rr_next % n;
        rr_next = (tgt + 1) % n;
      end
      q = tgt * pjd_pkg::NUM_PRIORITIES + p;
      r.core = 3'(tgt);
      r.prio = 2'(p);
      if (q_fill[q] >= pjd_pkg::QUEUE_DEPTH) begin
        r.status = pjd_pkg::ST_FULL;
      end else begin
        tag_mem[q*pjd_pkg::QUEUE_DEPTH + q_tail[q]] = it.job_tag;
        q_tail[q] = (q_tail[q] + 1) % pjd_pkg::QUEUE_DEPTH;
        q_fill[q]++;
        r.status = pjd_pkg::ST_QUEUED;
      end
    end else begin
      found = 1'b0;
      for (p = 0; p < pjd_pkg::NUM_PRIORITIES && !found; p++) begin
        q = it.fetch_core * pjd_pkg::NUM_PRIORITIES + p;
        if (q_fill[q] != 0) begin
          r.status = pjd_pkg::ST_DELIVERED;
          r.job = tag_mem[q*pjd_pkg::QUEUE_DEPTH + q_head[q]];
          r.prio = 2'(p);
          q_head[q] = (q_head[q] + 1) % pjd_pkg::QUEUE_DEPTH;
          q_fill[q]--;
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t mk_sub(logic [31:0] tag, logic [1:0] prio, logic hv,
                                       logic [15:0] hint);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_val: '0, it: '0, typed: 1'b0, res: '0};
    row.it.func = FN_SUBMIT;
    row.it.job_tag = tag;
    row.it.prio = prio;
    row.it.hint_valid = hv;
    row.it.hint_core = hint;
    row.it.fetch_core = 3'($urandom);
    return row;
  endfunction

  function automatic stim_row_t mk_fetch(logic [2:0] core);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cfg_val: '0, it: '0, typed: 1'b0, res: '0};
    row.it.func = FN_FETCH;
    // fields a fetch ignores still carry noise
    row.it.job_tag = $urandom;
    row.it.prio = 2'($urandom);
    row.it.hint_valid = 1'($urandom);
    row.it.hint_core = 16'($urandom);
    row.it.fetch_core = core;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(logic [3:0] v);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cfg_val: v, it: '0, typed: 1'b0, res: '0};
    return row;
  endfunction

  function automatic stim_row_t with_res(stim_row_t row, pjd_pkg::status_e st,
                                         logic [2:0] core, logic [31:0] job,
                                         logic [1:0] prio);
    row.typed = 1'b1;
    row.res = '{status: st, core: core, job: job, prio: prio};
    return row;
  endfunction

  task automatic add_row(input stim_row_t row);
    stim_rows[n_rows] = row;
    n_rows++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [3:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_cores = v;
    settings_used++;
  endtask

  task automatic send_row(input stim_row_t row);
    int            gap;
    dispatch_res_t want;
    if (row.is_cfg) begin
      wait_idle();
      write_cfg(row.cfg_val);
    end else begin
      gap = send_calm ? 0 : gap_len();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {2'b00, row.it.fetch_core, row.it.hint_core, row.it.hint_valid,
                        row.it.prio, row.it.job_tag};
      s_axis_tuser  <= row.it.func;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      want = dispatch_predict(row.it);
      if (row.typed) want = row.res;
      exp_buf[exp_wr % EXP_DEPTH] = want;
      exp_wr++;
      items_sent++;
    end
  endtask

  function automatic stim_row_t rnd_submit();
    logic [15:0] hint;
    hint = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    return mk_sub($urandom, 2'($urandom_range(0, 3)), 1'($urandom), hint);
  endfunction

  // result side: sink stalls and scoreboard
  always @(posedge clk_i) begin : sink_side
    dispatch_res_t got;
    dispatch_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = pjd_pkg::status_e'(m_axis_tuser);
        got.core   = m_axis_tdata[2:0];
        got.job    = m_axis_tdata[34:3];
        got.prio   = m_axis_tdata[36:35];
        results_seen++;
        status_seen[m_axis_tuser]++;
        if (exp_wr == exp_rd) begin
          fail_count++;
          if (report_count < 10) begin
            $display("%0t: unexpected result status=%0d core=%0d job=%h prio=%0d",
                     $realtime, got.status, got.core, got.job, got.prio);
            report_count++;
          end
        end else begin
          want = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== want) begin
            fail_count++;
            if (report_count < 10) begin
              $display("%0t: mismatch exp status=%0d core=%0d job=%h prio=%0d",
                       $realtime, want.status, want.core, want.job, want.prio);
              $display("%0t:          got status=%0d core=%0d job=%h prio=%0d",
                       $realtime, got.status, got.core, got.job, got.prio);
              report_count++;
            end
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 4) == 0) sink_stall = gap_len();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_seq
    logic [3:0]  cfg_choices [12] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd7,
                                     4'd9, 4'd4, 4'd6, 4'd12};
    int          random_sent;
    int          phase;
    int          phase_len;
    int          phase_items;
    int          burst;
    int          r;
    logic [15:0] hint;
    logic [1:0]  prio;
    logic [2:0]  core;

    for (int i = 0; i < pjd_pkg::NUM_QUEUES; i++) begin
      q_fill[i] = 0;
      q_head[i] = 0;
      q_tail[i] = 0;
    end
    rr_next = 0;
    cfg_cores = 4'd8;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, eight cores active after reset
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_EMPTY, 3'd0, 32'h0, 2'd0));
    add_row(with_res(mk_fetch(3'd7), pjd_pkg::ST_EMPTY, 3'd7, 32'h0, 2'd0));
    add_row(with_res(mk_sub(32'h0, 2'd0, 1'b1, 16'h0000),
                     pjd_pkg::ST_QUEUED, 3'd0, 32'h0, 2'd0));
    add_row(with_res(mk_sub(32'hffff_ffff, 2'd2, 1'b1, 16'hffff),
                     pjd_pkg::ST_QUEUED, 3'd7, 32'h0, 2'd2));
    // priority beyond the lowest class folds onto it
    add_row(with_res(mk_sub(32'h1234_5678, 2'd3, 1'b1, 16'd3),
                     pjd_pkg::ST_QUEUED, 3'd3, 32'h0, 2'd2));
    // no hint: round robin, hint field is ignored
    add_row(with_res(mk_sub(32'ha5a5_a5a5, 2'd1, 1'b0, 16'hffff),
                     pjd_pkg::ST_QUEUED, 3'd0, 32'h0, 2'd1));
    add_row(with_res(mk_sub(32'h5a5a_5a5a, 2'd0, 1'b0, 16'h0000),
                     pjd_pkg::ST_QUEUED, 3'd1, 32'h0, 2'd0));
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_DELIVERED, 3'd0, 32'h0, 2'd0));
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_DELIVERED, 3'd0, 32'ha5a5_a5a5, 2'd1));
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_EMPTY, 3'd0, 32'h0, 2'd0));
    add_row(with_res(mk_fetch(3'd7), pjd_pkg::ST_DELIVERED, 3'd7, 32'hffff_ffff, 2'd2));
    add_row(with_res(mk_fetch(3'd3), pjd_pkg::ST_DELIVERED, 3'd3, 32'h1234_5678, 2'd2));
    add_row(with_res(mk_fetch(3'd1), pjd_pkg::ST_DELIVERED, 3'd1, 32'h5a5a_5a5a, 2'd0));
    // counter at 2 meets a count of 3
    add_row(mk_cfg(4'd3));
    add_row(with_res(mk_sub(32'h1111_1111, 2'd0, 1'b0, 16'h0),
                     pjd_pkg::ST_QUEUED, 3'd2, 32'h0, 2'd0));
    add_row(with_res(mk_sub(32'h2222_2222, 2'd1, 1'b1, 16'hffff),
                     pjd_pkg::ST_QUEUED, 3'd0, 32'h0, 2'd1));
    // zero cores behaves as one
    add_row(mk_cfg(4'd0));
    add_row(with_res(mk_sub(32'h3333_3333, 2'd2, 1'b0, 16'h0),
                     pjd_pkg::ST_QUEUED, 3'd0, 32'h0, 2'd2));
    // core 2 is inactive now but still holds a job
    add_row(with_res(mk_fetch(3'd2), pjd_pkg::ST_DELIVERED, 3'd2, 32'h1111_1111, 2'd0));
    // count above the core limit saturates
    add_row(mk_cfg(4'd15));
    add_row(mk_sub(32'hdead_beef, 2'd0, 1'b1, 16'hfffe));
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_DELIVERED, 3'd0, 32'h2222_2222, 2'd1));
    add_row(with_res(mk_fetch(3'd0), pjd_pkg::ST_DELIVERED, 3'd0, 32'h3333_3333, 2'd2));
    add_row(mk_fetch(3'd6));

    for (int i = 0; i < n_rows; i++) send_row(stim_rows[i]);

    // random phases, one core-count setting each
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      send_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      send_row(mk_cfg(cfg_choices[phase % 12]));
      phase++;
      phase_len = $urandom_range(100, 180);
      phase_items = 0;
      while (phase_items < phase_len && random_sent < RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_row(rnd_submit());
          burst = 1;
        end else if (r < 75) begin
          send_row(mk_fetch(3'($urandom)));
          burst = 1;
        end else if (r < 85) begin
          // push one queue past full
          hint = 16'($urandom_range(0, 15));
          prio = 2'($urandom_range(0, 3));
          burst = $urandom_range(17, 19);
          for (int k = 0; k < burst; k++) send_row(mk_sub($urandom, prio, 1'b1, hint));
        end else if (r < 95) begin
          core = 3'($urandom);
          burst = $urandom_range(4, 20);
          for (int k = 0; k < burst; k++) send_row(mk_fetch(core));
        end else begin
          // hold the sender until the block has drained
          wait_idle();
          burst = 0;
        end
        phase_items += burst;
        random_sent += burst;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);

    $display("run covered %0d items, %0d results, %0d core-count settings",
             items_sent, results_seen, settings_used);
    $display("results by status: queued %0d, full %0d, delivered %0d, none waiting %0d",
             status_seen[pjd_pkg::ST_QUEUED], status_seen[pjd_pkg::ST_FULL],
             status_seen[pjd_pkg::ST_DELIVERED], status_seen[pjd_pkg::ST_EMPTY]);
    if (fail_count == 0 && exp_wr == exp_rd) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> per_core_priority_job_dispatcher.f
rtl/pjd_pkg.sv
rtl/pjd_ram.sv
rtl/pjd_seq.sv
rtl/per_core_priority_job_dispatcher.sv
dv/tb_per_core_priority_job_dispatcher.sv
